// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the median-of-three partition block.
// Depends on nothing; files that check their own logic include it by name.
// The SYNTH define empties every macro so synthesis sees no assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// ante holds at an edge, so cons holds at the same edge
`define HPM_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error("hpm: implication check failed");

// expr never holds at an edge
`define HPM_ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) !(expr)) \
        else $error("hpm: forbidden condition seen");

`else

`define HPM_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)

`define HPM_ASSERT_NEVER(lbl, clk_s, rst_s, expr)

`endif

`endif

// File: rtl/hpm_pkg.sv
// Package of the median-of-three partition block: sizes, types, the
// sequencer states and the pivot function. Depends on nothing.
`default_nettype none

package hpm_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int WORD_BITS    = 32;
    localparam int SPLIT_BITS   = 7;
    localparam int ADDR_BITS    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_BITS     = $clog2(MAX_ELEMENTS + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_BITS-1:0]        addr_t;
    typedef logic [CNT_BITS-1:0]         cnt_t;
    typedef logic [SPLIT_BITS-1:0]       split_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PIVOT,
        ST_LCHK,
        ST_RCHK,
        ST_SWAP,
        ST_EMIT
    } state_t;

    // one write and one read address per cycle into the element store
    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        addr_t raddr;
    } mem_req_t;

    function automatic word_t median3(input word_t a, input word_t b, input word_t c);
        word_t lo;
        word_t hi;
        word_t hc;
        lo = (a < b) ? a : b;
        hi = (a > b) ? a : b;
        hc = (hi < c) ? hi : c;
        return (lo > hc) ? lo : hc;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hpm_channels.sv
// Handshake channels of the partition block: input word and result word.
// Depends on hpm_pkg for the word type.
`default_nettype none

interface hpm_in_if;
    logic          valid;
    logic          ready;
    hpm_pkg::word_t value;
    logic          last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface hpm_out_if;
    logic            valid;
    logic            ready;
    hpm_pkg::word_t  element;
    hpm_pkg::split_t split_index;
    logic            truncated;
    logic            last_out;

    modport source (output valid, output element, output split_index,
                    output truncated, output last_out, input ready);
    modport sink   (input valid, input element, input split_index,
                    input truncated, input last_out, output ready);
endinterface

`default_nettype wire

// File: rtl/hpm_store.sv
// Element store: one write port, one read port, registered read data.
// Depends on hpm_pkg for the request struct and sizes.
`default_nettype none

module hpm_store (
    input  logic              clk,
    input  hpm_pkg::mem_req_t req,
    output hpm_pkg::word_t    rdata
);

    hpm_pkg::word_t mem [hpm_pkg::MAX_ELEMENTS];
    hpm_pkg::word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/hoare_partition_median3.sv
// Top level of the median-of-three Hoare partition block: load sequencer,
// partition walk and emit stage. Depends on hpm_pkg, hpm_channels, hpm_store.
//
//   port     dir   word fields
//   in_ch    sink  value, last_in
//   out_ch   src   element, split_index, truncated, last_out
//
// Load takes one word per cycle. A word marked last starts a run: the pivot
// state reads the first, last and middle word and forms the pivot, then the
// walk steps the indices and swaps words until they cross.
// Emit reads a word, then the output register takes it; the next read waits
// while out_ch stalls. Input is taken only in load, also while a result waits.
// Reset clears the count and the overflow flag; the store needs no clearing.
`default_nettype none

`include "assert_macros.svh"

module hoare_partition_median3 (
    input  logic         clk,
    input  logic         rst_n,
    hpm_in_if.sink       in_ch,
    hpm_out_if.source    out_ch
);

    hpm_pkg::state_t   state_reg, state_next;
    hpm_pkg::cnt_t     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [1:0]        step_reg, step_next;
    hpm_pkg::cnt_t     l_reg, l_next;
    hpm_pkg::cnt_t     rp_reg, rp_next;     // right index plus one
    hpm_pkg::cnt_t     k_reg, k_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              out_valid_reg, out_valid_next;

    hpm_pkg::word_t    a_reg, a_next;
    hpm_pkg::word_t    b_reg, b_next;
    hpm_pkg::word_t    pivot_reg, pivot_next;
    hpm_pkg::word_t    sl_reg, sl_next;
    hpm_pkg::word_t    sr_reg, sr_next;
    hpm_pkg::word_t    out_element_reg;
    hpm_pkg::split_t   out_split_reg;
    logic              out_trunc_reg;
    logic              out_last_reg;

    hpm_pkg::mem_req_t req;
    hpm_pkg::word_t    rdata;
    hpm_pkg::cnt_t     cnt_m1;
    hpm_pkg::cnt_t     mid;
    logic              in_fire;
    logic              out_fire;
    logic              slot_free;

    hpm_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign in_ch.ready = (state_reg == hpm_pkg::ST_LOAD);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_fire    = out_valid_reg && out_ch.ready;
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign cnt_m1      = count_reg - hpm_pkg::cnt_t'(1);
    assign mid         = cnt_m1 >> 1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        step_next      = step_reg;
        l_next         = l_reg;
        rp_next        = rp_reg;
        k_next         = k_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        pivot_next     = pivot_reg;
        sl_next        = sl_reg;
        sr_next        = sr_reg;
        req.we         = 1'b0;
        req.waddr      = '0;
        req.wdata      = in_ch.value;
        req.raddr      = '0;

        unique case (state_reg)
            hpm_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (count_reg < hpm_pkg::cnt_t'(hpm_pkg::MAX_ELEMENTS))
                    begin
                        req.we     = 1'b1;
                        req.waddr  = hpm_pkg::addr_t'(count_reg);
                        count_next = count_reg + hpm_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_ch.last_in)
                    begin
                        step_next  = 2'd0;
                        state_next = hpm_pkg::ST_PIVOT;
                    end
                end
            end

            hpm_pkg::ST_PIVOT:
            begin
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd0:
                    begin
                        req.raddr = '0;
                    end
                    2'd1:
                    begin
                        a_next    = rdata;
                        req.raddr = hpm_pkg::addr_t'(cnt_m1);
                    end
                    2'd2:
                    begin
                        b_next    = rdata;
                        req.raddr = hpm_pkg::addr_t'(mid);
                    end
                    default:
                    begin
                        pivot_next = hpm_pkg::median3(a_reg, b_reg, rdata);
                        l_next     = '0;
                        rp_next    = count_reg;
                        req.raddr  = '0;
                        state_next = hpm_pkg::ST_LCHK;
                    end
                endcase
            end

            hpm_pkg::ST_LCHK:
            begin
                // rdata holds the word at l
                if (l_reg < rp_reg && rdata < pivot_reg)
                begin
                    l_next    = l_reg + hpm_pkg::cnt_t'(1);
                    req.raddr = hpm_pkg::addr_t'(l_next);
                end
                else if (l_reg >= rp_reg)
                begin
                    k_next     = '0;
                    state_next = hpm_pkg::ST_EMIT;
                end
                else
                begin
                    sl_next    = rdata;
                    req.raddr  = hpm_pkg::addr_t'(rp_reg - hpm_pkg::cnt_t'(1));
                    state_next = hpm_pkg::ST_RCHK;
                end
            end

            hpm_pkg::ST_RCHK:
            begin
                // rdata holds the word at rp - 1
                if (rp_reg > l_reg && rdata > pivot_reg)
                begin
                    rp_next   = rp_reg - hpm_pkg::cnt_t'(1);
                    req.raddr = hpm_pkg::addr_t'(rp_next - hpm_pkg::cnt_t'(1));
                end
                else if (rp_reg <= l_reg)
                begin
                    k_next     = '0;
                    state_next = hpm_pkg::ST_EMIT;
                end
                else
                begin
                    // right side first, so the read of l + 1 next cycle sees it
                    req.we     = 1'b1;
                    req.waddr  = hpm_pkg::addr_t'(rp_reg - hpm_pkg::cnt_t'(1));
                    req.wdata  = sl_reg;
                    sr_next    = rdata;
                    state_next = hpm_pkg::ST_SWAP;
                end
            end

            hpm_pkg::ST_SWAP:
            begin
                req.we    = 1'b1;
                req.waddr = hpm_pkg::addr_t'(l_reg);
                req.wdata = sr_reg;
                l_next    = l_reg + hpm_pkg::cnt_t'(1);
                rp_next   = rp_reg - hpm_pkg::cnt_t'(1);
                req.raddr = hpm_pkg::addr_t'(l_next);
                if (l_next < rp_next)
                begin
                    state_next = hpm_pkg::ST_LCHK;
                end
                else
                begin
                    k_next     = '0;
                    state_next = hpm_pkg::ST_EMIT;
                end
            end

            hpm_pkg::ST_EMIT:
            begin
                if (pend_reg)
                begin
                    if (pend_last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = hpm_pkg::ST_LOAD;
                    end
                end
                else if (k_reg < count_reg && slot_free)
                begin
                    req.raddr      = hpm_pkg::addr_t'(k_reg);
                    k_next         = k_reg + hpm_pkg::cnt_t'(1);
                    pend_next      = 1'b1;
                    pend_last_next = (k_next == count_reg);
                end
            end

            default:
            begin
                state_next = hpm_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpm_pkg::ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            step_reg      <= 2'd0;
            l_reg         <= '0;
            rp_reg        <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            step_reg      <= step_next;
            l_reg         <= l_next;
            rp_reg        <= rp_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        pivot_reg <= pivot_next;
        sl_reg    <= sl_next;
        sr_reg    <= sr_next;
        if (pend_reg)
        begin
            out_element_reg <= rdata;
            out_split_reg   <= hpm_pkg::split_t'(l_reg);
            out_trunc_reg   <= ovf_reg;
            out_last_reg    <= pend_last_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.element     = out_element_reg;
    assign out_ch.split_index = out_split_reg;
    assign out_ch.truncated   = out_trunc_reg;
    assign out_ch.last_out    = out_last_reg;

    // a read result lands only in an empty output slot
    `HPM_ASSERT_IMPLY(a_slot_empty, clk, rst_n, pend_reg, !out_valid_reg)
    // swap only while the indices have not crossed
    `HPM_ASSERT_IMPLY(a_swap_order, clk, rst_n, state_reg == hpm_pkg::ST_SWAP, l_reg < rp_reg)
    // a run always has at least one stored word
    `HPM_ASSERT_IMPLY(a_run_nonempty, clk, rst_n, state_reg != hpm_pkg::ST_LOAD,
                      count_reg != '0)
    // walk indices stay inside the loaded range
    `HPM_ASSERT_NEVER(a_walk_bounds, clk, rst_n,
                      (state_reg == hpm_pkg::ST_LCHK || state_reg == hpm_pkg::ST_RCHK)
                      && (l_reg > count_reg || rp_reg > count_reg))

endmodule

`default_nettype wire
